@@ design/vmu_pkg.sv @@
// Shared types, widths and operation codes of the vector math unit.
`default_nettype none
package vmu_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int OP_BITS   = 3;

  localparam logic [OP_BITS-1:0] OP_ADD   = 3'd0;
  localparam logic [OP_BITS-1:0] OP_SUB   = 3'd1;
  localparam logic [OP_BITS-1:0] OP_CROSS = 3'd2;
  localparam logic [OP_BITS-1:0] OP_LEN   = 3'd3;
  localparam logic [OP_BITS-1:0] OP_NORM  = 3'd4;

  localparam logic [WORD_BITS-1:0] SMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] SMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  typedef struct packed {
    logic [OP_BITS-1:0]          req_type;
    logic signed [WORD_BITS-1:0] ax;
    logic signed [WORD_BITS-1:0] ay;
    logic signed [WORD_BITS-1:0] az;
    logic signed [WORD_BITS-1:0] bx;
    logic signed [WORD_BITS-1:0] by;
    logic signed [WORD_BITS-1:0] bz;
  } req_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] rx;
    logic signed [WORD_BITS-1:0] ry;
    logic signed [WORD_BITS-1:0] rz;
    logic [WORD_BITS-1:0]        magnitude;
    logic                        overflow;
    logic                        zero_length;
  } res_t;

  // What one component lane hands on after its two stages.
  typedef struct packed {
    logic [WORD_BITS-1:0]   vec;
    logic                   ovf;
    logic [2*WORD_BITS-1:0] sq;
    logic [WORD_BITS-1:0]   amag;
    logic                   aneg;
  } lane_t;

  // Per-request side data carried alongside the root and divider pipelines.
  typedef struct packed {
    logic [OP_BITS-1:0]          op;
    logic [2:0][WORD_BITS-1:0]   vec;
    logic                        ovf;
    logic [2:0][WORD_BITS-1:0]   amag;
    logic [2:0]                  aneg;
  } side_t;

endpackage
`default_nettype wire

@@ design/vmu_lane.sv @@
// One component lane: saturating add or subtract, cross term, square and magnitude.
`default_nettype none
module vmu_lane (
  input  wire logic                                   clk,
  input  wire logic [vmu_pkg::OP_BITS-1:0]            op,
  input  wire logic signed [vmu_pkg::WORD_BITS-1:0]   a,
  input  wire logic signed [vmu_pkg::WORD_BITS-1:0]   b,
  input  wire logic signed [vmu_pkg::WORD_BITS-1:0]   p,
  input  wire logic signed [vmu_pkg::WORD_BITS-1:0]   q,
  input  wire logic signed [vmu_pkg::WORD_BITS-1:0]   u,
  input  wire logic signed [vmu_pkg::WORD_BITS-1:0]   v,
  output vmu_pkg::lane_t                              lane
);
  localparam int W = vmu_pkg::WORD_BITS;
  localparam int F = vmu_pkg::FRAC_BITS;

  logic signed [W:0]     ext_sum;
  logic [W-1:0]          as_val;
  logic                  as_ovf;

  logic [vmu_pkg::OP_BITS-1:0] op1;
  logic [W-1:0]          as_r;
  logic                  as_ovf_r;
  logic signed [2*W-1:0] pq;
  logic signed [2*W-1:0] uv;
  logic signed [2*W-1:0] sq1;
  logic [W-1:0]          amag1;
  logic                  aneg1;

  logic signed [2*W:0]   diff;
  logic [2*W-F-W+1:0]    hi_bits;
  logic                  cr_ok;
  logic [W-1:0]          cr_val;

  always_comb begin
    if (op == vmu_pkg::OP_SUB) begin
      ext_sum = {a[W-1], a} - {b[W-1], b};
    end else begin
      ext_sum = {a[W-1], a} + {b[W-1], b};
    end
    as_ovf = ext_sum[W] != ext_sum[W-1];
    if (as_ovf) begin
      as_val = ext_sum[W] ? vmu_pkg::SMIN : vmu_pkg::SMAX;
    end else begin
      as_val = ext_sum[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    op1      <= op;
    as_r     <= as_val;
    as_ovf_r <= as_ovf;
    pq       <= p * q;
    uv       <= u * v;
    sq1      <= a * a;
    aneg1    <= a[W-1];
    amag1    <= a[W-1] ? W'(-a) : W'(a);
  end

  // The exact difference is shifted right by the fraction width, rounding down.
  always_comb begin
    diff    = {pq[2*W-1], pq} - {uv[2*W-1], uv};
    hi_bits = diff[2*W:F+W-1];
    cr_ok   = (&hi_bits) | ~(|hi_bits);
    if (cr_ok) begin
      cr_val = diff[F+W-1:F];
    end else begin
      cr_val = diff[2*W] ? vmu_pkg::SMIN : vmu_pkg::SMAX;
    end
  end

  always_ff @(posedge clk) begin
    if (op1 == vmu_pkg::OP_CROSS) begin
      lane.vec <= cr_val;
      lane.ovf <= ~cr_ok;
    end else begin
      lane.vec <= as_r;
      lane.ovf <= as_ovf_r;
    end
    lane.sq   <= $unsigned(sq1);
    lane.amag <= amag1;
    lane.aneg <= aneg1;
  end

endmodule
`default_nettype wire

@@ design/vmu_sqrt.sv @@
// Pipelined integer square root, one root bit per stage.
`default_nettype none
module vmu_sqrt (
  input  wire logic                               clk,
  input  wire logic [2*vmu_pkg::WORD_BITS-1:0]    rad,
  output logic [vmu_pkg::WORD_BITS-1:0]           root
);
  localparam int W = vmu_pkg::WORD_BITS;

  logic [W+1:0]   rem_q  [W];
  logic [W-1:0]   root_q [W];
  logic [2*W-1:0] rad_q  [W];
  logic [W+1:0]   rem_d  [W];
  logic [W-1:0]   root_d [W];
  logic [2*W-1:0] rad_d  [W];

  always_comb begin
    for (int i = 0; i < W; i++) begin
      logic [W+1:0]   rem_p;
      logic [W-1:0]   root_p;
      logic [2*W-1:0] rad_p;
      logic [W+3:0]   cur;
      logic [W+3:0]   trial;
      if (i == 0) begin
        rem_p  = '0;
        root_p = '0;
        rad_p  = rad;
      end else begin
        rem_p  = rem_q[i-1];
        root_p = root_q[i-1];
        rad_p  = rad_q[i-1];
      end
      cur   = {rem_p, rad_p[2*W-1:2*W-2]};
      trial = {2'b00, root_p, 2'b01};
      if (cur >= trial) begin
        rem_d[i]  = (W+2)'(cur - trial);
        root_d[i] = {root_p[W-2:0], 1'b1};
      end else begin
        rem_d[i]  = (W+2)'(cur);
        root_d[i] = {root_p[W-2:0], 1'b0};
      end
      rad_d[i] = {rad_p[2*W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < W; i++) begin
      rem_q[i]  <= rem_d[i];
      root_q[i] <= root_d[i];
      rad_q[i]  <= rad_d[i];
    end
  end

  assign root = root_q[W-1];

endmodule
`default_nettype wire

@@ design/vmu_div.sv @@
// Pipelined restoring divider giving magnitude times two to the fraction width over the root.
`default_nettype none
module vmu_div (
  input  wire logic                            clk,
  input  wire logic [vmu_pkg::WORD_BITS-1:0]   num,
  input  wire logic [vmu_pkg::WORD_BITS-1:0]   den,
  output logic [vmu_pkg::FRAC_BITS:0]          quo,
  output logic [vmu_pkg::WORD_BITS-1:0]        den_out
);
  localparam int W    = vmu_pkg::WORD_BITS;
  localparam int F    = vmu_pkg::FRAC_BITS;
  localparam int NSTG = F + 1;

  logic [W:0]   r_q [NSTG];
  logic [F:0]   q_q [NSTG];
  logic [W-1:0] d_q [NSTG];
  logic [W:0]   r_d [NSTG];
  logic [F:0]   q_d [NSTG];
  logic [W-1:0] d_d [NSTG];

  always_comb begin
    for (int j = 0; j < NSTG; j++) begin
      logic [W:0] r_in;
      logic [F:0] q_in;
      logic       ge;
      if (j == 0) begin
        r_in   = {1'b0, num};
        q_in   = '0;
        d_d[j] = den;
      end else begin
        r_in   = {r_q[j-1][W-1:0], 1'b0};
        q_in   = q_q[j-1];
        d_d[j] = d_q[j-1];
      end
      ge     = r_in >= {1'b0, d_d[j]};
      r_d[j] = ge ? r_in - {1'b0, d_d[j]} : r_in;
      q_d[j] = {q_in[F-1:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < NSTG; j++) begin
      r_q[j] <= r_d[j];
      q_q[j] <= q_d[j];
      d_q[j] <= d_d[j];
    end
  end

  assign quo     = q_q[NSTG-1];
  assign den_out = d_q[NSTG-1];

endmodule
`default_nettype wire

@@ design/vector3_math_unit.sv @@
// Top level of the vector math unit: three component lanes, root merge and dividers.
// The unit works at the Q16.16 widths. One request is accepted every cycle while busy is low;
// busy is raised only by reset, never in operation. The receiver must take every result in
// the cycle it appears; the block itself does not enforce it. The depth is set mostly by
// the root pipeline (one bit per stage) and the dividers. Synchronous reset empties the
// strobe pipeline; busy is set while rst is high and clears at the first edge with rst low.
`default_nettype none
module vector3_math_unit (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire vmu_pkg::req_t req,
  output logic               done,
  output vmu_pkg::res_t      result
);
  localparam int W      = vmu_pkg::WORD_BITS;
  localparam int F      = vmu_pkg::FRAC_BITS;
  // Strobe pipeline: first lane stage, second lane stage, sum, root stages, divider stages, output.
  localparam int LAT    = W + F + 5;
  // Side data waits from the lane output until the quotients are ready.
  localparam int SDEPTH = W + F + 2;
  // Tap at which the component magnitudes meet the root at the dividers.
  localparam int ATAP   = W;

  logic              accept;
  logic [LAT-1:0]    vld;

  vmu_pkg::lane_t    lane [3];
  logic [2*W-1:0]    sum_sq;
  logic [W-1:0]      root;
  vmu_pkg::side_t    side_in;
  vmu_pkg::side_t    side [SDEPTH];
  logic [F:0]        quo [3];
  logic [W-1:0]      den_out [3];
  vmu_pkg::side_t    fin;
  vmu_pkg::res_t     result_next;

  // A request is taken whenever start is seen outside reset recovery.
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      vld  <= '0;
    end else begin
      busy <= 1'b0;
      vld  <= {vld[LAT-2:0], accept};
    end
  end

  assign done = vld[LAT-1];

  // Each lane takes its own component of a and b plus the two products that form its
  // component of the cross product a x b.
  vmu_lane u_lane_x (
    .clk (clk), .op (req.req_type), .a (req.ax), .b (req.bx),
    .p (req.ay), .q (req.bz), .u (req.by), .v (req.az), .lane (lane[0])
  );
  vmu_lane u_lane_y (
    .clk (clk), .op (req.req_type), .a (req.ay), .b (req.by),
    .p (req.bx), .q (req.az), .u (req.ax), .v (req.bz), .lane (lane[1])
  );
  vmu_lane u_lane_z (
    .clk (clk), .op (req.req_type), .a (req.az), .b (req.bz),
    .p (req.ax), .q (req.by), .u (req.bx), .v (req.ay), .lane (lane[2])
  );

  // The operation code travels in step with the lane stages to join the side data.
  logic [vmu_pkg::OP_BITS-1:0] op1;
  logic [vmu_pkg::OP_BITS-1:0] op2;

  always_ff @(posedge clk) begin
    op1 <= req.req_type;
    op2 <= op1;
  end

  // Merging stage: the three squares are summed, which never exceeds the double word.
  always_ff @(posedge clk) begin
    sum_sq <= lane[0].sq + lane[1].sq + lane[2].sq;
  end

  vmu_sqrt u_sqrt (
    .clk  (clk),
    .rad  (sum_sq),
    .root (root)
  );

  always_comb begin
    side_in.op  = op2;
    side_in.ovf = lane[0].ovf | lane[1].ovf | lane[2].ovf;
    for (int k = 0; k < 3; k++) begin
      side_in.vec[k]  = lane[k].vec;
      side_in.amag[k] = lane[k].amag;
      side_in.aneg[k] = lane[k].aneg;
    end
  end

  always_ff @(posedge clk) begin
    side[0] <= side_in;
    for (int s = 1; s < SDEPTH; s++) begin
      side[s] <= side[s-1];
    end
  end

  // No component magnitude exceeds the floor root, so each quotient stays at or below
  // one in the fraction format.
  vmu_div u_div_x (
    .clk (clk), .num (side[ATAP].amag[0]), .den (root),
    .quo (quo[0]), .den_out (den_out[0])
  );
  vmu_div u_div_y (
    .clk (clk), .num (side[ATAP].amag[1]), .den (root),
    .quo (quo[1]), .den_out (den_out[1])
  );
  vmu_div u_div_z (
    .clk (clk), .num (side[ATAP].amag[2]), .den (root),
    .quo (quo[2]), .den_out (den_out[2])
  );

  assign fin = side[SDEPTH-1];

  // Result selection. The root always fits the word, so length and normalize never
  // saturate; a zero root on normalize forces a zero vector and raises zero_length.
  always_comb begin
    logic [W-1:0] nq [3];
    for (int k = 0; k < 3; k++) begin
      nq[k] = {{(W-F-1){1'b0}}, quo[k]};
      if (fin.aneg[k]) begin
        nq[k] = W'(-nq[k]);
      end
    end
    result_next = '0;
    case (fin.op)
      vmu_pkg::OP_ADD, vmu_pkg::OP_SUB, vmu_pkg::OP_CROSS: begin
        result_next.rx       = fin.vec[0];
        result_next.ry       = fin.vec[1];
        result_next.rz       = fin.vec[2];
        result_next.overflow = fin.ovf;
      end
      vmu_pkg::OP_LEN: begin
        result_next.magnitude = den_out[0];
      end
      vmu_pkg::OP_NORM: begin
        if (den_out[0] == '0) begin
          result_next.zero_length = 1'b1;
        end else begin
          result_next.rx        = nq[0];
          result_next.ry        = nq[1];
          result_next.rz        = nq[2];
          result_next.magnitude = den_out[0];
        end
      end
      default: begin
        result_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (vld[LAT-2]) begin
      result <= result_next;
    end
  end

endmodule
`default_nettype wire
